// ----- hw/rtl/cwt_pkg.sv -----
// ============================================================================
// cwt_pkg: shared types and constants for the card whitelist table
// Command codes, the slot record, and default table geometry.
// ============================================================================
`default_nettype none

package cwt_pkg;

    localparam int DEF_TABLE_DEPTH = 256;

    localparam logic [2:0] OP_SEARCH = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_SET    = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_FORMAT = 3'd4;

    localparam logic [1:0] PERM_FREE = 2'd0;

    typedef struct packed {
        logic [31:0] uid;
        logic [1:0]  perm;
    } t_slot;

    // control from the sequencer to every cell of the ring
    typedef struct packed {
        logic shift;
        logic clr;
    } t_ring_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/cwt_cell.sv -----
// ============================================================================
// cwt_cell: one slot of the rotating table ring
// Holds one identifier and permission; loads its neighbor on shift.
// ============================================================================
`default_nettype none

module cwt_cell
    import cwt_pkg::*;
(
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire t_ring_ctl  i_ctl,
    input  wire t_slot      i_d,
    output t_slot           o_q
);

    logic [1:0]  r_perm;
    logic [31:0] r_uid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_perm <= PERM_FREE;
        end else if (i_ctl.shift) begin
            r_perm <= i_d.perm;
        end
    end

    // identifier is only meaningful while perm is nonzero
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_uid <= i_d.uid;
        end
    end

    assign o_q = '{uid: r_uid, perm: r_perm};

endmodule

`default_nettype wire

// ----- hw/rtl/cwt_ctrl.sv -----
// ============================================================================
// cwt_ctrl: command sequencer at the head of the ring
// Inspects the head slot each cycle of a full rotation and writes it back.
// ============================================================================
`default_nettype none

module cwt_ctrl
    import cwt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [2:0]  i_opcode,
    input  wire  [31:0] i_card_uid,
    input  wire  [7:0]  i_slot_index,
    input  wire         i_auto_slot,
    input  wire  [1:0]  i_perm_bits,
    output logic        o_valid,
    input  wire         i_stall,
    output logic        o_ok,
    output logic [7:0]  o_result_slot,
    output logic [1:0]  o_result_perm,
    output logic [8:0]  o_used_count,
    output t_ring_ctl   o_ctl,
    input  wire t_slot  i_head,
    output t_slot       o_wb
);

    localparam int CW    = $clog2(TABLE_DEPTH);
    localparam int IW    = ((CW > 8) ? CW : 8) + 1;
    localparam int CNT_W = CW + 1;
    localparam int CNW   = (CNT_W > 9) ? CNT_W : 9;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;

    t_state             r_state;
    logic [CW-1:0]      r_cnt;
    logic [2:0]         r_op;
    logic [31:0]        r_uid;
    logic [7:0]         r_idx;
    logic               r_auto;
    logic [1:0]         r_perm;
    logic               r_found;
    logic               r_ok;
    logic [7:0]         r_slot;
    logic [1:0]         r_rperm;
    logic [CNT_W-1:0]   r_count;
    logic               r_ov;
    logic               r_o_ok;
    logic [7:0]         r_o_slot;
    logic [1:0]         r_o_perm;
    logic [CNT_W-1:0]   r_o_count;

    logic in_acc, idx_ok, idx_match, full;
    logic take, s_ok, s_inc, s_dec;
    logic [1:0] s_perm;

    assign o_stall = (r_state != S_IDLE);
    assign in_acc  = i_valid && !o_stall;
    assign idx_ok  = (TABLE_DEPTH > 256) || (IW'(i_slot_index) < IW'(TABLE_DEPTH));
    assign full    = (r_count >= CNT_W'(TABLE_DEPTH));
    assign idx_match = (IW'(r_cnt) == IW'(r_idx));

    assign o_ctl = '{shift: (r_state == S_SCAN),
                     clr:   (in_acc && (i_opcode == OP_FORMAT))};

    always_comb begin
        o_wb   = i_head;
        take   = 1'b0;
        s_ok   = 1'b0;
        s_inc  = 1'b0;
        s_dec  = 1'b0;
        s_perm = i_head.perm;
        unique case (r_op)
            OP_SEARCH: begin
                take = !r_found && (i_head.perm != PERM_FREE) && (i_head.uid == r_uid);
                s_ok = 1'b1;
            end
            OP_ADD: begin
                take = r_auto ? (!r_found && (i_head.perm == PERM_FREE)) : idx_match;
                if (take) begin
                    if ((i_head.perm != PERM_FREE) && (i_head.uid != r_uid)) begin
                        s_ok = 1'b0;
                    end else begin
                        s_ok = 1'b1;
                        o_wb.perm = i_head.perm | r_perm;
                        o_wb.uid  = r_uid;
                        s_inc = (i_head.perm == PERM_FREE);
                    end
                end
                s_perm = o_wb.perm;
            end
            OP_SET: begin
                take = idx_match;
                if (take && (i_head.perm != PERM_FREE)) begin
                    s_ok = 1'b1;
                    o_wb.perm = r_perm;
                    if (r_perm == PERM_FREE) begin
                        o_wb.uid = '0;
                        s_dec = (r_count != '0);
                    end
                end
                s_perm = r_perm;
            end
            OP_READ: begin
                take = idx_match;
                s_ok = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && !i_stall && (r_state != S_DONE)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op    <= i_opcode;
                        r_uid   <= i_card_uid;
                        r_idx   <= i_slot_index;
                        r_auto  <= i_auto_slot;
                        r_perm  <= i_perm_bits;
                        r_cnt   <= '0;
                        r_found <= 1'b0;
                        r_ok    <= 1'b0;
                        r_slot  <= '0;
                        r_rperm <= '0;
                        r_state <= S_SCAN;
                        priority case (i_opcode)
                            OP_SEARCH: ;
                            OP_ADD: begin
                                if ((i_perm_bits == PERM_FREE) || full ||
                                    (!i_auto_slot && !idx_ok)) begin
                                    r_state <= S_DONE;
                                end
                            end
                            OP_SET, OP_READ: begin
                                if (!idx_ok) begin
                                    r_state <= S_DONE;
                                end
                            end
                            OP_FORMAT: begin
                                r_ok    <= 1'b1;
                                r_count <= '0;
                                r_state <= S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (take) begin
                        r_found <= 1'b1;
                        r_ok    <= s_ok;
                        r_slot  <= s_ok ? 8'(IW'(r_cnt)) : 8'd0;
                        r_rperm <= s_ok ? s_perm : PERM_FREE;
                        if (s_inc) begin
                            r_count <= r_count + 1'b1;
                        end else if (s_dec) begin
                            r_count <= r_count - 1'b1;
                        end
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(TABLE_DEPTH - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ov || !i_stall) begin
                        r_ov      <= 1'b1;
                        r_o_ok    <= r_ok;
                        r_o_slot  <= r_slot;
                        r_o_perm  <= r_rperm;
                        r_o_count <= r_count;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_ov;
    assign o_ok          = r_o_ok;
    assign o_result_slot = r_o_slot;
    assign o_result_perm = r_o_perm;
    assign o_used_count  = 9'(CNW'(r_o_count));

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("occupied count beyond table depth");

    a_format_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.clr |=> (r_count == '0) && (r_state == S_DONE))
        else $error("format did not clear count");

    a_ok_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_o_ok) |-> (r_o_slot == '0) && (r_o_perm == PERM_FREE))
        else $error("failed command reports slot data");

    a_scan_no_out_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> !$rose(r_ov))
        else $error("result issued mid-scan");

endmodule

`default_nettype wire

// ----- hw/rtl/card_whitelist_table.sv -----
// ============================================================================
// card_whitelist_table: card identifier whitelist with permission masks
// Top level: ring of slot cells plus the command sequencer.
// ============================================================================
// Usage:
//   Input channel (i_valid / o_stall) carries one command beat: opcode,
//   card_uid, slot_index, auto_slot, perm_bits. Output channel
//   (o_valid / i_stall) returns one result beat per command: ok,
//   result_slot, result_perm, used_count.
//   Search, add, set and read rotate the whole slot ring once past the
//   head cell in the scan state, then pass the done state before the
//   result is registered; format, rejected adds/out-of-range indexes and
//   unused opcodes skip the scan and go straight to the done state. One
//   command is in flight at a time, so the next command is not taken
//   until the current result moves into the output register; o_stall is
//   high from accept until then. The output register holds a finished beat
//   while i_stall is high; a following command can be accepted meanwhile,
//   and its result waits in the sequencer until the output register drains.
//   Reset frees every slot and zeroes the occupied count.
// ============================================================================
`default_nettype none

module card_whitelist_table
    import cwt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [2:0]  i_opcode,
    input  wire  [31:0] i_card_uid,
    input  wire  [7:0]  i_slot_index,
    input  wire         i_auto_slot,
    input  wire  [1:0]  i_perm_bits,
    output logic        o_valid,
    input  wire         i_stall,
    output logic        o_ok,
    output logic [7:0]  o_result_slot,
    output logic [1:0]  o_result_perm,
    output logic [8:0]  o_used_count
);

    t_ring_ctl ctl;
    t_slot     wb;
    t_slot     q [TABLE_DEPTH];

    cwt_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_card_uid    (i_card_uid),
        .i_slot_index  (i_slot_index),
        .i_auto_slot   (i_auto_slot),
        .i_perm_bits   (i_perm_bits),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_ok          (o_ok),
        .o_result_slot (o_result_slot),
        .o_result_perm (o_result_perm),
        .o_used_count  (o_used_count),
        .o_ctl         (ctl),
        .i_head        (q[0]),
        .o_wb          (wb)
    );

    // cell k loads cell k+1; the last cell takes the head's write-back
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        cwt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_d     ((k == TABLE_DEPTH - 1) ? wb : q[(k + 1) % TABLE_DEPTH]),
            .o_q     (q[k])
        );
    end

endmodule

`default_nettype wire
